// ===== rtl/lmh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_pkg
// Shared constants and types of the byte stream lane mix hash.
// ----------------------------------------------------------------------------
package lmh_pkg;

  // Default sizes
  localparam int unsigned LaneCountDef = 8;
  localparam int unsigned CountBitsDef = 28;

  // Mix constants
  localparam int unsigned MixNum      = 46886;
  localparam logic [31:0] MixStart    = 32'd7;
  localparam logic [31:0] AddConst    = 32'h85eb_ca6b;
  localparam logic [31:0] XorConst    = 32'hc2b2_ae35;
  localparam int unsigned ShiftLeft   = 15;
  localparam int unsigned ShiftRight  = 21;
  localparam int unsigned TrailBytes  = 8;

  // Quotient width of the fixed numerator divide
  localparam int unsigned DivW = $clog2(MixNum + 1);
  // Signed remainder by ten, -9..9
  localparam int unsigned RemW = 5;
  localparam logic signed [RemW-1:0] RemStart = 5'sd7;

  // Per-cycle commands from the sequencer to the lane datapath
  typedef struct packed {
    logic clear;    // return all lanes to zero
    logic load_k;   // register the lane factor k
    logic add_prod; // mix byte and k * (lane + 1)
    logic finish;   // shift-xor, add, xor, write the lane
  } mix_ctrl_t;

endpackage : lmh_pkg
`default_nettype wire

// ===== rtl/lmh_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_in_if
// Input word channel: one message byte with its flags.
// ----------------------------------------------------------------------------
interface lmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface : lmh_in_if
`default_nettype wire

// ===== rtl/lmh_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_out_if
// Output word channel: one digest lane per word.
// ----------------------------------------------------------------------------
interface lmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        too_long;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, output too_long, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, input too_long, output ready);
endinterface : lmh_out_if
`default_nettype wire

// ===== rtl/byte_stream_lane_mix_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_lane_mix_hash
// Mixes message bytes into LANE_COUNT lanes and streams the digest words.
// ----------------------------------------------------------------------------
// Each lane step runs the restoring divider of the k factor, then loads k,
// adds the product and writes the lane; a byte steps through every lane.
// The end of a message adds 8 trailer bytes, then LANE_COUNT digest words at
// one per cycle while the sink is ready. Not ready while a byte is mixed.
// Reset (async, active low) zeroes the lanes, the byte count and the
// overflow flag, and sets the mix counter to seven; so does each digest end.
// ----------------------------------------------------------------------------
module byte_stream_lane_mix_hash #(
  parameter int unsigned LANE_COUNT = lmh_pkg::LaneCountDef,
  parameter int unsigned COUNT_BITS = lmh_pkg::CountBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lmh_in_if.sink     item_i,
  lmh_out_if.source  digest_o
);
  import lmh_pkg::*;

  localparam int unsigned IdxW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastLane = IdxW'(LANE_COUNT - 1);
  localparam int unsigned TbW = $clog2(TrailBytes);
  localparam logic [TbW-1:0] LastTb = TbW'(TrailBytes - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DSTART = 7'b0000010,
    S_DWAIT  = 7'b0000100,
    S_KLOAD  = 7'b0001000,
    S_ADD    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [31:0]            mc_q, mc_d;
  logic signed [RemW-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [IdxW-1:0]        lane_q, lane_d;
  logic [TbW-1:0]         tb_q, tb_d;
  logic                   trail_q, trail_d;
  logic                   end_q, end_d;
  logic [7:0]             data_q, data_d;

  logic                   out_valid_q, out_valid_d;
  logic [31:0]            out_word_q, out_word_d;
  logic [2:0]             out_idx_q, out_idx_d;
  logic                   out_last_q, out_last_d;
  logic                   out_long_q, out_long_d;

  logic                   accept;
  logic                   mc_neg;
  logic                   mc_zero;
  logic [31:0]            mag;
  logic                   div_busy;
  logic [DivW-1:0]        quot;
  mix_ctrl_t              ctrl;
  logic [31:0]            lane_word;
  logic [63:0]            bits64;
  logic [5:0]             trail_sh;
  logic [7:0]             trail_byte;
  logic [7:0]             mix_byte;
  logic [IdxW+2:0]        idx_ext;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  // Magnitude of the mix counter for the divider
  assign mc_neg  = mc_q[31];
  assign mc_zero = (mc_q == '0);
  assign mag     = mc_neg ? (32'd0 - mc_q) : mc_q;

  // Big-endian length trailer byte
  assign bits64     = {{(64-COUNT_BITS-3){1'b0}}, cnt_q, 3'b000};
  assign trail_sh   = {LastTb - tb_q, 3'b000};
  assign trail_byte = 8'(bits64 >> trail_sh);
  assign mix_byte   = trail_q ? trail_byte : data_q;

  assign idx_ext = {3'b000, lane_q};

  lmh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_DSTART),
    .divisor_i (mag),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  lmh_mix #(
    .LANE_COUNT (LANE_COUNT),
    .IDX_W      (IdxW)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .idx_i   (lane_q),
    .byte_i  (mix_byte),
    .quot_i  (quot),
    .neg_i   (mc_neg),
    .zero_i  (mc_zero),
    .rem_i   (rem_q),
    .lane_o  (lane_word)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mc_d        = mc_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    lane_d      = lane_q;
    tb_d        = tb_q;
    trail_d     = trail_q;
    end_d       = end_q;
    data_d      = data_q;
    ctrl        = '0;
    out_valid_d = out_valid_q && !digest_o.ready;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_long_d  = out_long_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          data_d  = item_i.data_byte;
          end_d   = item_i.end_of_message;
          trail_d = !item_i.has_byte;
          tb_d    = '0;
          lane_d  = '0;
          // Count the byte, saturate and flag on overrun
          if (item_i.has_byte) begin
            if (cnt_q == '1) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          if (item_i.has_byte || item_i.end_of_message) begin
            state_d = S_DSTART;
          end
        end
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (!div_busy) begin
          state_d = S_KLOAD;
        end
      end
      S_KLOAD: begin
        ctrl.load_k = 1'b1;
        state_d     = S_ADD;
      end
      S_ADD: begin
        ctrl.add_prod = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        ctrl.finish = 1'b1;
        mc_d        = mc_q + 32'd1;
        // Track the truncated remainder of the counter by ten
        if (mc_q == 32'h7fff_ffff) begin
          rem_d = -5'sd8;
        end else if (!mc_neg) begin
          rem_d = (rem_q == 5'sd9) ? 5'sd0 : rem_q + 5'sd1;
        end else begin
          rem_d = (rem_q == 5'sd0) ? -5'sd9 : rem_q + 5'sd1;
        end
        if (lane_q != LastLane) begin
          lane_d  = lane_q + 1'b1;
          state_d = S_DSTART;
        end else begin
          lane_d = '0;
          if (!trail_q) begin
            if (end_q) begin
              trail_d = 1'b1;
              tb_d    = '0;
              state_d = S_DSTART;
            end else begin
              state_d = S_IDLE;
            end
          end else if (tb_q != LastTb) begin
            tb_d    = tb_q + 1'b1;
            state_d = S_DSTART;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        // Advance one digest word when the output stage is free
        if (!out_valid_q || digest_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = lane_word;
          out_idx_d   = idx_ext[2:0];
          out_last_d  = (lane_q == LastLane);
          out_long_d  = ovf_q;
          if (lane_q == LastLane) begin
            ctrl.clear = 1'b1;
            mc_d       = MixStart;
            rem_d      = RemStart;
            cnt_d      = '0;
            ovf_d      = 1'b0;
            lane_d     = '0;
            state_d    = S_IDLE;
          end else begin
            lane_d = lane_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mc_q        <= MixStart;
      rem_q       <= RemStart;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      lane_q      <= '0;
      tb_q        <= '0;
      trail_q     <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mc_q        <= mc_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      lane_q      <= lane_d;
      tb_q        <= tb_d;
      trail_q     <= trail_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_long_q <= out_long_d;
  end

  assign digest_o.valid       = out_valid_q;
  assign digest_o.digest_word = out_word_q;
  assign digest_o.word_index  = out_idx_q;
  assign digest_o.last_word   = out_last_q;
  assign digest_o.too_long    = out_long_q;

endmodule : byte_stream_lane_mix_hash
`default_nettype wire

// ===== rtl/lmh_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_div
// Radix-2 restoring divider of the fixed numerator by a 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmh_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [31:0]              divisor_i,
  output logic                          busy_o,
  output logic [lmh_pkg::DivW-1:0]      quot_o
);
  import lmh_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);
  localparam logic [DivW-1:0] Num = DivW'(MixNum);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [31:0]     dvs_q, dvs_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            ge;

  // Shift in the next numerator bit and try a subtract
  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = {{(32-DivW-1){1'b0}}, trial} >= dvs_q;
  assign diff  = trial - dvs_q[DivW:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW - 1);
      rem_d  = '0;
      quo_d  = Num;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule : lmh_div
`default_nettype wire

// ===== rtl/lmh_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_mix
// Lane registers and the shared lane update: k factor, multiply-add,
// shift-xor and constant add / xor, one lane at a time.
// ----------------------------------------------------------------------------
module lmh_mix #(
  parameter int unsigned LANE_COUNT = lmh_pkg::LaneCountDef,
  parameter int unsigned IDX_W      = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lmh_pkg::mix_ctrl_t              ctrl_i,
  input  wire logic [IDX_W-1:0]                idx_i,
  input  wire logic [7:0]                      byte_i,
  input  wire logic [lmh_pkg::DivW-1:0]        quot_i,
  input  wire logic                            neg_i,
  input  wire logic                            zero_i,
  input  wire logic signed [lmh_pkg::RemW-1:0] rem_i,
  output logic [31:0]                          lane_o
);
  import lmh_pkg::*;

  logic [31:0]      lanes_q [LANE_COUNT];
  logic [31:0]      k_q, k_d;
  logic [31:0]      h_q, h_d;
  logic [31:0]      quot_ext;
  logic [31:0]      q_signed;
  logic [31:0]      byte_ext;
  logic [IDX_W:0]   factor;
  logic [31:0]      prod;
  logic [31:0]      shx;
  logic [31:0]      lane_new;

  assign lane_o = lanes_q[idx_i];

  // Signed quotient minus the signed remainder by ten
  assign quot_ext = {{(32-DivW){1'b0}}, quot_i};
  assign q_signed = zero_i ? '0 : (neg_i ? (32'd0 - quot_ext) : quot_ext);
  assign k_d      = q_signed - 32'(rem_i);

  // Sign-extend the byte and weight k by the lane number
  assign byte_ext = {{24{byte_i[7]}}, byte_i};
  assign factor   = {1'b0, idx_i} + 1'b1;
  assign prod     = k_q * {{(32-IDX_W-1){1'b0}}, factor};
  assign h_d      = (lane_o ^ byte_ext) + prod;

  // Final scramble of the lane
  assign shx      = h_q ^ ((h_q << ShiftLeft) | (h_q >> ShiftRight));
  assign lane_new = (shx + AddConst) ^ XorConst;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_k) begin
      k_q <= k_d;
    end
    if (ctrl_i.add_prod) begin
      h_q <= h_d;
    end
  end

  // Hold lanes; clear at digest end, write back on finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        lanes_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        lanes_q[i] <= '0;
      end
    end else if (ctrl_i.finish) begin
      lanes_q[idx_i] <= lane_new;
    end
  end

endmodule : lmh_mix
`default_nettype wire
